// ===== src/trs_pkg.sv =====
// Package for the threshold region segmenter: types and constants shared by its modules.
package trs_pkg;

  localparam int unsigned FRAME_INDEX_BITS = 24;
  localparam int unsigned QW         = 17;
  localparam logic [16:0] Q_ONE      = 17'd65536;
  localparam int unsigned CW         = 24;
  localparam int unsigned SUMW       = 41;
  localparam int unsigned LENW       = 25;
  localparam logic [24:0] RUN_LEN_MAX = 25'h1FFFFFF;
  localparam logic [23:0] CNT_MAX    = 24'hFFFFFF;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MIN_REGION = 2'd1;
  localparam logic [1:0] CFG_MERGE_GAP = 2'd2;

  localparam logic KIND_REGION  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One result beat, before packing onto the stream.
  typedef struct packed {
    logic        kind;
    logic [23:0] start_frame;
    logic [23:0] end_frame;
    logic [16:0] confidence;
    logic [16:0] energy;
    logic [23:0] region_count;
    logic [23:0] vocal_frames;
    logic [16:0] overall_confidence;
    logic        last_result;
  } trs_result_t;

  // Request and answer of the shared divider.
  typedef struct packed {
    logic            start;
    logic [SUMW-1:0] dividend;
    logic [LENW-1:0] divisor;
  } trs_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [16:0] quotient;
  } trs_div_rsp_t;

endpackage

// ===== src/trs_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, quotient cut to its low 17 bits.
module trs_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  trs_pkg::trs_div_req_t req,
  output trs_pkg::trs_div_rsp_t rsp
);
  import trs_pkg::*;

  localparam int unsigned CNTW = $clog2(SUMW + 1);

  logic [SUMW-1:0] quo_r, quo_nxt;
  logic [LENW:0]   rem_r, rem_nxt;
  logic [LENW-1:0] dvs_r, dvs_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [LENW:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[LENW-1:0], quo_r[SUMW-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CNTW'(SUMW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[SUMW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUMW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[16:0];

endmodule

// ===== src/threshold_region_segmenter_core.sv =====
// Top level of the threshold region segmenter: frame tracking, region merging and summary.
//
// Usage. Each in_ beat carries one frame: the Q1.16 likelihood in in_tdata and the
// final-frame flag on in_tlast. Out_ beats carry region records and, after the final
// frame, one summary; out_tuser is the kind (0 region, 1 summary) and out_tlast marks the
// last result caused by one frame. A frame causes zero to three results.
// Timing. A frame that closes no region passes the evaluate and flush states before the
// block is ready again. A frame that closes a kept region runs the shared serial divider
// once for its mean confidence, and takes longer when an older region is sent out. The
// final frame may also flush a region and run the divider once more for the mean over all
// regions. Each result beat waits in the output register until taken, and no frame is
// taken while it waits, so output stalls lengthen the handling of a frame. The shared
// divider produces one quotient bit per cycle. One frame at a time.
// Reset. rst_n, synchronous and active low, clears all tracking state and loads the
// register defaults (threshold 0.5, 22 frames for both distances). After the final frame
// all tracking state returns to that reset value; the registers keep their values.
// Stall. While out_tready is low the pending result is held and no frame is taken.
// The user must write configuration (cfg_we, cfg_addr, cfg_wdata) only in idle, unchecked.
module threshold_region_segmenter_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [16:0] likelihood
  input  logic         in_tlast,   // final_frame
  output logic         out_tvalid,
  input  logic         out_tready,
  // [23:0] start_frame, [47:24] end_frame, [64:48] confidence, [81:65] energy,
  // [105:82] region_count, [129:106] vocal_frames, [146:130] overall_confidence
  output logic [151:0] out_tdata,
  output logic         out_tlast,  // last_result
  output logic         out_tuser,  // kind
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata
);
  import trs_pkg::*;

  localparam int unsigned FW = FRAME_INDEX_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV     = 3'd1;
  localparam logic [2:0] S_TAKE    = 3'd2;
  localparam logic [2:0] S_FLUSH   = 3'd3;
  localparam logic [2:0] S_SUMDIV  = 3'd4;
  localparam logic [2:0] S_SUMMARY = 3'd5;
  localparam logic [2:0] S_OUT     = 3'd6;
  localparam logic [2:0] S_EVAL    = 3'd7;

  logic [16:0] thr_r;
  logic [23:0] min_len_r, merge_gap_r;

  logic [2:0]      st_r, st_nxt;
  logic [2:0]      ret_r, ret_nxt;   // state to resume after an output beat
  logic [FW-1:0]   fidx_r, fidx_nxt;
  logic            in_reg_r, in_reg_nxt;
  logic [FW-1:0]   ostart_r, ostart_nxt;
  logic [SUMW-1:0] rsum_r, rsum_nxt;
  logic [LENW-1:0] rlen_r, rlen_nxt;
  logic            pv_r, pv_nxt;
  logic [FW-1:0]   ps_r, ps_nxt, pe_r, pe_nxt;
  logic [16:0]     pc_r, pc_nxt, pen_r, pen_nxt;
  logic [23:0]     nreg_r, nreg_nxt, vtot_r, vtot_nxt;
  logic [SUMW-1:0] ctot_r, ctot_nxt;
  logic [16:0]     lk_r, lk_nxt;
  logic            fin_r, fin_nxt;
  logic            close_r, close_nxt; // a kept region awaits its mean
  logic [16:0]     conf_r, conf_nxt;
  trs_result_t     res_r, res_nxt;
  logic            ov_r, ov_nxt;

  trs_div_req_t dreq;
  trs_div_rsp_t drsp;

  logic [16:0]   lk_sat;
  logic          vocal;
  logic [FW-1:0] open_len, gap, span;
  logic [24:0]   vsum;

  trs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign lk_sat   = (in_tdata[16:0] > Q_ONE) ? Q_ONE : in_tdata[16:0];
  assign vocal    = lk_r >= thr_r;
  assign open_len = fidx_r - ostart_r;
  assign gap      = ostart_r - pe_r;
  assign span     = pe_r - ps_r;
  assign vsum     = {1'b0, vtot_r} + 25'(span);

  assign in_tready = (st_r == S_IDLE) && !ov_r;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r;
    fidx_nxt = fidx_r; in_reg_nxt = in_reg_r; ostart_nxt = ostart_r;
    rsum_nxt = rsum_r; rlen_nxt = rlen_r;
    pv_nxt = pv_r; ps_nxt = ps_r; pe_nxt = pe_r; pc_nxt = pc_r; pen_nxt = pen_r;
    nreg_nxt = nreg_r; vtot_nxt = vtot_r; ctot_nxt = ctot_r;
    lk_nxt = lk_r; fin_nxt = fin_r; close_nxt = close_r; conf_nxt = conf_r;
    res_nxt = res_r; ov_nxt = ov_r;
    dreq = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          lk_nxt = lk_sat;
          fin_nxt = in_tlast;
          st_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        close_nxt = 1'b0;
        if (vocal && !in_reg_r) begin
          in_reg_nxt = 1'b1;
          ostart_nxt = fidx_r;
          rsum_nxt = SUMW'(lk_r);
          rlen_nxt = LENW'(1);
          st_nxt = S_FLUSH;
        end else if ((!vocal || fin_r) && in_reg_r) begin
          in_reg_nxt = 1'b0;
          if (rlen_r < RUN_LEN_MAX) begin
            rsum_nxt = rsum_r + SUMW'(lk_r);
            rlen_nxt = rlen_r + 1'b1;
          end
          if (24'(open_len) >= min_len_r) begin
            close_nxt = 1'b1;
            st_nxt = S_DIV;
          end else begin
            st_nxt = S_FLUSH;
          end
        end else begin
          if (in_reg_r && rlen_r < RUN_LEN_MAX) begin
            rsum_nxt = rsum_r + SUMW'(lk_r);
            rlen_nxt = rlen_r + 1'b1;
          end
          st_nxt = S_FLUSH;
        end
      end
      S_DIV: begin
        // Start the divider on the region sum, then wait for the mean.
        if (!drsp.busy && !drsp.done && close_r) begin
          dreq.start = 1'b1;
          dreq.dividend = rsum_r;
          dreq.divisor = rlen_r;
          close_nxt = 1'b0;
        end else if (drsp.done) begin
          conf_nxt = drsp.quotient;
          st_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        if (pv_r && 24'(gap) < merge_gap_r) begin
          pe_nxt = fidx_r;
          if (conf_r > pc_r) pc_nxt = conf_r;
          pen_nxt = 17'(({1'b0, pen_r} + {1'b0, conf_r}) >> 1);
          st_nxt = S_FLUSH;
        end else if (pv_r && !ov_r) begin
          // Emit the older region; come back here to install the new one.
          // On a non-final frame this record is the only result of the frame.
          res_nxt = '0;
          res_nxt.kind = KIND_REGION;
          res_nxt.start_frame = 24'(ps_r);
          res_nxt.end_frame = 24'(pe_r);
          res_nxt.confidence = pc_r;
          res_nxt.energy = pen_r;
          res_nxt.last_result = !fin_r;
          ov_nxt = 1'b1;
          if (nreg_r != CNT_MAX) nreg_nxt = nreg_r + 1'b1;
          vtot_nxt = vsum[24] ? CNT_MAX : vsum[23:0];
          ctot_nxt = ctot_r + SUMW'(pc_r);
          pv_nxt = 1'b0;
        end else if (!pv_r) begin
          pv_nxt = 1'b1;
          ps_nxt = ostart_r;
          pe_nxt = fidx_r;
          pc_nxt = conf_r;
          pen_nxt = conf_r;
          st_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!fin_r) begin
          fidx_nxt = fidx_r + 1'b1;
          st_nxt = S_IDLE;
        end else if (pv_r) begin
          if (!ov_r) begin
            res_nxt = '0;
            res_nxt.kind = KIND_REGION;
            res_nxt.start_frame = 24'(ps_r);
            res_nxt.end_frame = 24'(pe_r);
            res_nxt.confidence = pc_r;
            res_nxt.energy = pen_r;
            ov_nxt = 1'b1;
            if (nreg_r != CNT_MAX) nreg_nxt = nreg_r + 1'b1;
            vtot_nxt = vsum[24] ? CNT_MAX : vsum[23:0];
            ctot_nxt = ctot_r + SUMW'(pc_r);
            pv_nxt = 1'b0;
          end
        end else if (nreg_r != '0) begin
          dreq.start = 1'b1;
          dreq.dividend = ctot_r;
          dreq.divisor = LENW'(nreg_r);
          st_nxt = S_SUMDIV;
        end else begin
          conf_nxt = '0;
          st_nxt = S_SUMMARY;
        end
      end
      S_SUMDIV: begin
        if (drsp.done) begin
          conf_nxt = drsp.quotient;
          st_nxt = S_SUMMARY;
        end
      end
      S_SUMMARY: begin
        if (!ov_r) begin
          res_nxt = '0;
          res_nxt.kind = KIND_SUMMARY;
          res_nxt.region_count = nreg_r;
          res_nxt.vocal_frames = vtot_r;
          res_nxt.overall_confidence = conf_r;
          res_nxt.last_result = 1'b1;
          ov_nxt = 1'b1;
          fidx_nxt = '0; in_reg_nxt = 1'b0; ostart_nxt = '0;
          rsum_nxt = '0; rlen_nxt = '0; pv_nxt = 1'b0;
          ps_nxt = '0; pe_nxt = '0; pc_nxt = '0; pen_nxt = '0;
          nreg_nxt = '0; vtot_nxt = '0; ctot_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      S_OUT: st_nxt = ret_r;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 17'd32768;
      min_len_r <= 24'd22;
      merge_gap_r <= 24'd22;
      st_r <= S_IDLE; ret_r <= S_IDLE;
      fidx_r <= '0; in_reg_r <= 1'b0; ostart_r <= '0;
      rsum_r <= '0; rlen_r <= '0;
      pv_r <= 1'b0; ps_r <= '0; pe_r <= '0; pc_r <= '0; pen_r <= '0;
      nreg_r <= '0; vtot_r <= '0; ctot_r <= '0;
      close_r <= 1'b0; fin_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_THRESHOLD:  thr_r <= cfg_wdata[16:0];
          CFG_MIN_REGION: min_len_r <= cfg_wdata;
          CFG_MERGE_GAP:  merge_gap_r <= cfg_wdata;
          default: ;
        endcase
      end
      st_r <= st_nxt; ret_r <= ret_nxt;
      fidx_r <= fidx_nxt; in_reg_r <= in_reg_nxt; ostart_r <= ostart_nxt;
      rsum_r <= rsum_nxt; rlen_r <= rlen_nxt;
      pv_r <= pv_nxt; ps_r <= ps_nxt; pe_r <= pe_nxt; pc_r <= pc_nxt; pen_r <= pen_nxt;
      nreg_r <= nreg_nxt; vtot_r <= vtot_nxt; ctot_r <= ctot_nxt;
      close_r <= close_nxt; fin_r <= fin_nxt; ov_r <= ov_nxt;
    end
    lk_r <= lk_nxt;
    conf_r <= conf_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last_result;
  assign out_tdata  = {5'd0, res_r.overall_confidence, res_r.vocal_frames,
                       res_r.region_count, res_r.energy, res_r.confidence,
                       res_r.end_frame, res_r.start_frame};

endmodule
